// File: sv/ncc_pkg.sv
// Package for the NMEA sentence checksum checker.
// Character codes, phase and result-kind codes, hex digit decoder.
// No dependencies.
`default_nettype none

package ncc_pkg;

    localparam logic [7:0] CH_START = 8'h24;   // '$'
    localparam logic [7:0] CH_DELIM = 8'h2A;   // '*'

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_HEX_HI  = 2'd2;
    localparam logic [1:0] PH_HEX_LO  = 2'd3;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // 0-9, A-F, a-f; anything else decodes as zero with ok low
    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t       h;
        logic [7:0] d;
        h.ok  = 1'b1;
        h.val = 4'd0;
        d     = 8'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            d = c - 8'h30;
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            d = c - 8'h37;
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            d = c - 8'h57;
        end
        else
        begin
            h.ok = 1'b0;
        end
        h.val = d[3:0];
        return h;
    endfunction

endpackage

`default_nettype wire

// File: sv/nmea_sentence_checksum_checker_top.sv
// NMEA sentence checksum checker, top level.
// Throughput: one byte per cycle while in_stall is low. An accepted byte waits
// in the input register; the frame state update and the result register load
// happen together when it advances, which a stalled result beat holds back.
// in_stall rises only while the input register holds a byte and the result
// register holds a stalled beat.
// Reset (rst_n, async low): hunting for '$', sums and error flag cleared,
// input and result registers empty.
// Depends on ncc_pkg.
`default_nettype none

module nmea_sentence_checksum_checker_top
    import ncc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input byte channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    // result channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      kind,
    output logic [7:0]      byte_value,
    output logic [7:0]      computed_sum,
    output logic [7:0]      received_sum
);

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;

    // frame state
    logic [1:0] phase_reg,   phase_next;
    logic [7:0] xor_reg,     xor_next;
    logic [3:0] hi_nib_reg,  hi_nib_next;
    logic       hex_err_reg, hex_err_next;

    // result register
    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] byte_value_reg;
    logic [7:0] csum_reg;
    logic [7:0] rsum_reg;

    logic       out_free;
    logic       advance;
    logic       res_valid;
    logic [1:0] res_kind;
    logic [7:0] res_byte;
    logic [7:0] res_csum;
    logic [7:0] res_rsum;
    hex_t       hx;
    logic [7:0] rsum;

    // The result register frees up when empty or when its beat is taken.
    // The held byte moves forward whenever the result slot is free.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    always_comb
    begin
        hx           = hex_digit(s1_byte_reg);
        rsum         = {hi_nib_reg, hx.val};
        phase_next   = phase_reg;
        xor_next     = xor_reg;
        hi_nib_next  = hi_nib_reg;
        hex_err_next = hex_err_reg;
        res_valid    = 1'b0;
        res_kind     = KIND_PAYLOAD;
        res_byte     = 8'd0;
        res_csum     = 8'd0;
        res_rsum     = 8'd0;
        case (phase_reg)
            PH_HUNT:
            begin
                if (s1_byte_reg == CH_START)
                begin
                    xor_next     = 8'd0;
                    hex_err_next = 1'b0;
                    hi_nib_next  = 4'd0;
                    phase_next   = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (s1_byte_reg == CH_DELIM)
                begin
                    phase_next = PH_HEX_HI;
                end
                else
                begin
                    // '$' in here is plain payload
                    xor_next  = xor_reg ^ s1_byte_reg;
                    res_valid = 1'b1;
                    res_byte  = s1_byte_reg;
                end
            end
            PH_HEX_HI:
            begin
                if (!hx.ok)
                begin
                    hex_err_next = 1'b1;
                end
                hi_nib_next = hx.val;
                phase_next  = PH_HEX_LO;
            end
            PH_HEX_LO:
            begin
                res_valid  = 1'b1;
                res_csum   = xor_reg;
                res_rsum   = rsum;
                res_kind   = (!hex_err_reg && hx.ok && (rsum == xor_reg)) ?
                             KIND_GOOD : KIND_BAD;
                hex_err_next = hex_err_reg | !hx.ok;
                phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HUNT;
            xor_reg       <= 8'd0;
            hi_nib_reg    <= 4'd0;
            hex_err_reg   <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg   <= phase_next;
                xor_reg     <= xor_next;
                hi_nib_reg  <= hi_nib_next;
                hex_err_reg <= hex_err_next;
            end

            if (out_free)
            begin
                out_valid_reg <= advance && res_valid;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (advance && res_valid)
        begin
            kind_reg       <= res_kind;
            byte_value_reg <= res_byte;
            csum_reg       <= res_csum;
            rsum_reg       <= res_rsum;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign byte_value   = byte_value_reg;
    assign computed_sum = csum_reg;
    assign received_sum = rsum_reg;

    // A good verdict always carries matching sums.
    a_good_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_GOOD |-> computed_sum == received_sum)
        else $error("good verdict with mismatched sums");

    // Payload beats carry zeroed sums; verdicts carry a zero byte.
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_PAYLOAD && computed_sum == 8'd0 &&
                       received_sum == 8'd0) ||
                      ((kind == KIND_GOOD || kind == KIND_BAD) && byte_value == 8'd0))
        else $error("unused result field not zero");

    // A verdict always sends the frame back to hunting.
    a_verdict_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_HEX_LO |=> phase_reg == PH_HUNT)
        else $error("verdict did not return to hunt");

    // Input only stalls while the held byte is blocked by a full result slot.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
